### rtl/core/interaction_type_dictionary_macros.svh
// assertion helpers for the interaction type dictionary
`ifndef INTERACTION_TYPE_DICTIONARY_MACROS_SVH
`define INTERACTION_TYPE_DICTIONARY_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every edge out of reset
`define ITD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("itd check failed");
// consequent holds in the cycle after the antecedent
`define ITD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itd check failed");
`else
`define ITD_ASSERT_ALWAYS(label, expr)
`define ITD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/itd_pkg.sv
`default_nettype none
package itd_pkg;

  localparam logic [2:0] KIND_ATOM    = 3'd0;
  localparam logic [2:0] KIND_BOND    = 3'd1;
  localparam logic [2:0] KIND_ANGLE   = 3'd2;
  localparam logic [2:0] KIND_TORSION = 3'd3;
  localparam logic [2:0] KIND_PLANE   = 3'd4;
  localparam int unsigned NUM_KINDS   = 5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] name_first;
    logic [31:0] name_second;
    logic [31:0] name_third;
    logic [31:0] name_fourth;
    logic [15:0] atom_first;
    logic [15:0] atom_second;
    logic [15:0] atom_third;
    logic [15:0] atom_fourth;
  } itd_in_t;

  typedef struct packed {
    logic [7:0]  type_index;
    logic        newly_added;
    logic        unknown_rank;
    logic        table_full;
    logic [15:0] out_atom_first;
    logic [15:0] out_atom_second;
    logic [15:0] out_atom_third;
    logic [15:0] out_atom_fourth;
  } itd_out_t;

endpackage
`default_nettype wire

### rtl/core/itd_rank_cell.sv
`default_nettype none
module itd_rank_cell import itd_pkg::*; #(
  parameter int unsigned IW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic [31:0]   key,
  input  wire logic          in_v,
  input  wire logic [IW-1:0] in_idx,
  input  wire logic [31:0]   in_name,
  output logic               nb_v,
  output logic [IW-1:0]      nb_idx,
  output logic [31:0]        nb_name,
  output logic               hit,
  output logic [IW-1:0]      rank
);

  logic          v_r, hit_r;
  logic [IW-1:0] idx_r, rank_r;
  logic [31:0]   name_r, key_r;
  logic          take;

  // first matching entry wins
  assign take = in_v && !hit_r && !clear && (in_name == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v_r <= in_v;
      if (clear) begin
        hit_r <= 1'b0;
      end else if (take) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= in_idx;
    name_r <= in_name;
    if (clear) begin
      key_r <= key;
    end
    if (take) begin
      rank_r <= in_idx;
    end
  end

  assign nb_v    = v_r;
  assign nb_idx  = idx_r;
  assign nb_name = name_r;
  assign hit     = hit_r;
  assign rank    = rank_r;

endmodule
`default_nettype wire

### rtl/core/interaction_type_dictionary.sv
// sequence: non-atom terms first scan the atom types in use for ranks, then one ordering
// state, then a search of that kind's table, then the result shows; atoms skip the scan
// flow: one term at a time, no new term until the result is taken; both scans walk the
// type memory through its single read port, one entry per cycle
// reset: synchronous active low, clears per-kind counts and control; memory left as is
`default_nettype none
`include "interaction_type_dictionary_macros.svh"
module interaction_type_dictionary import itd_pkg::*; #(
  parameter int unsigned TYPE_SLOTS = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire itd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output itd_out_t      out_data
);

  localparam int unsigned SW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam int unsigned UW = $clog2(TYPE_SLOTS + 1);
  localparam int unsigned CW = $clog2(TYPE_SLOTS + 8);
  localparam int unsigned AW = $clog2(NUM_KINDS * TYPE_SLOTS);
  localparam int unsigned DEPTH = NUM_KINDS * TYPE_SLOTS;

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RANK   = 5'b00010,
    S_ORDER  = 5'b00100,
    S_SEARCH = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // captured request, unused positions zeroed
  logic [2:0]  kind_r;
  logic [31:0] nm_r [4];
  logic [15:0] at_r [4];
  logic [31:0] nm_in [4];
  logic [15:0] at_in [4];

  // canonical key and atoms after ordering
  logic [127:0] key_r, key_nxt;
  logic [15:0]  ao_r [4];
  logic [15:0]  ao_nxt [4];
  logic         unk_r, unk_nxt;

  // per-kind entry counts
  logic [UW-1:0] used_r [NUM_KINDS];
  logic [UW-1:0] used_k, used_a;

  // shared scan counter and memory read pipe
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          issue;
  logic          rd_v_r;
  logic [SW-1:0] rd_idx_r;
  logic [127:0]  rd_data_r;
  logic [AW-1:0] raddr, base;
  logic [127:0]  mem [DEPTH];
  logic          we;
  logic [AW-1:0] waddr;

  // chain of rank cells, one per name position
  logic          c_v   [5];
  logic [SW-1:0] c_idx [5];
  logic [31:0]   c_nm  [5];
  logic          hit   [4];
  logic [SW-1:0] rnk   [4];

  itd_out_t res_r, res_nxt;
  logic     out_valid_r;
  logic     accept, clear;
  logic     match, scan_end;
  logic [31:0] idx32_hit, idx32_new;

  assign accept   = in_valid && !in_stall;
  assign clear    = accept;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  assign used_k = used_r[kind_r];
  assign used_a = used_r[KIND_ATOM];
  assign base   = AW'(kind_r) * AW'(TYPE_SLOTS);

  // mask unused positions by kind
  always_comb begin
    nm_in[0] = in_data.name_first;
    nm_in[1] = in_data.name_second;
    nm_in[2] = in_data.name_third;
    nm_in[3] = in_data.name_fourth;
    at_in[0] = in_data.atom_first;
    at_in[1] = in_data.atom_second;
    at_in[2] = in_data.atom_third;
    at_in[3] = in_data.atom_fourth;
    if (in_data.kind == KIND_ATOM) begin
      nm_in[1] = '0;
      at_in[1] = '0;
    end
    if (in_data.kind == KIND_ATOM || in_data.kind == KIND_BOND) begin
      nm_in[2] = '0;
      at_in[2] = '0;
    end
    if (in_data.kind != KIND_TORSION && in_data.kind != KIND_PLANE) begin
      nm_in[3] = '0;
      at_in[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_data.kind;
      for (int j = 0; j < 4; j++) begin
        nm_r[j] <= nm_in[j];
        at_r[j] <= at_in[j];
      end
    end
  end

  // read issue: rank scan walks atom names, search walks the kind's table
  always_comb begin
    issue = 1'b0;
    raddr = '0;
    if (state_r == S_RANK && cnt_r < CW'(used_a)) begin
      issue = 1'b1;
      raddr = AW'(cnt_r);
    end else if (state_r == S_SEARCH && cnt_r < CW'(used_k)) begin
      issue = 1'b1;
      raddr = base + AW'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
    rd_idx_r  <= cnt_r[SW-1:0];
    if (we) begin
      mem[waddr] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
    end
  end

  // rank chain is fed only during the rank scan
  assign c_v[0]   = rd_v_r && (state_r == S_RANK);
  assign c_idx[0] = rd_idx_r;
  assign c_nm[0]  = rd_data_r[31:0];

  for (genvar g = 0; g < 4; g++) begin : g_cell
    itd_rank_cell #(.IW(SW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (clear),
      .key     (nm_in[g]),
      .in_v    (c_v[g]),
      .in_idx  (c_idx[g]),
      .in_name (c_nm[g]),
      .nb_v    (c_v[g+1]),
      .nb_idx  (c_idx[g+1]),
      .nb_name (c_nm[g+1]),
      .hit     (hit[g]),
      .rank    (rnk[g])
    );
  end

  // rank p above rank q, unknown ranks count as minus one
  function automatic logic rank_gt(input logic kp, input logic [SW-1:0] sp,
                                   input logic kq, input logic [SW-1:0] sq);
    rank_gt = kp && (!kq || sp > sq);
  endfunction

  // canonical ordering from the four ranks
  always_comb begin
    logic [31:0]   n [4];
    logic [15:0]   a [4];
    logic          k [4];
    logic [SW-1:0] s [4];
    logic [31:0]   tn;
    logic [15:0]   ta;
    logic          tk;
    logic [SW-1:0] ts;
    tn = '0;
    ta = '0;
    tk = 1'b0;
    ts = '0;
    for (int j = 0; j < 4; j++) begin
      n[j] = nm_r[j];
      a[j] = at_r[j];
      k[j] = hit[j];
      s[j] = rnk[j];
    end
    unk_nxt = 1'b0;
    unique case (kind_r)
      KIND_BOND: begin
        unk_nxt = !k[0] || !k[1];
        if (rank_gt(k[0], s[0], k[1], s[1])) begin
          tn = n[0]; n[0] = n[1]; n[1] = tn;
          ta = a[0]; a[0] = a[1]; a[1] = ta;
        end
      end
      KIND_ANGLE: begin
        unk_nxt = !k[0] || !k[2];
        if (rank_gt(k[0], s[0], k[2], s[2])) begin
          tn = n[0]; n[0] = n[2]; n[2] = tn;
          ta = a[0]; a[0] = a[2]; a[2] = ta;
        end
      end
      KIND_TORSION: begin
        unk_nxt = !k[1] || !k[2];
        if (rank_gt(k[1], s[1], k[2], s[2])) begin
          tn = n[1]; n[1] = n[2]; n[2] = tn;
          ta = a[1]; a[1] = a[2]; a[2] = ta;
          tn = n[0]; n[0] = n[3]; n[3] = tn;
          ta = a[0]; a[0] = a[3]; a[3] = ta;
        end else if (n[1] == n[2]) begin
          unk_nxt = unk_nxt || !k[0] || !k[3];
          if (rank_gt(k[0], s[0], k[3], s[3])) begin
            tn = n[0]; n[0] = n[3]; n[3] = tn;
            ta = a[0]; a[0] = a[3]; a[3] = ta;
            ta = a[1]; a[1] = a[2]; a[2] = ta;
          end
        end
      end
      KIND_PLANE: begin
        // center stays, sort the three outer positions
        unk_nxt = !k[0] || !k[2] || !k[3];
        if (rank_gt(k[0], s[0], k[2], s[2])) begin
          tn = n[0]; n[0] = n[2]; n[2] = tn;
          ta = a[0]; a[0] = a[2]; a[2] = ta;
          tk = k[0]; k[0] = k[2]; k[2] = tk;
          ts = s[0]; s[0] = s[2]; s[2] = ts;
        end
        if (rank_gt(k[2], s[2], k[3], s[3])) begin
          tn = n[2]; n[2] = n[3]; n[3] = tn;
          ta = a[2]; a[2] = a[3]; a[3] = ta;
          tk = k[2]; k[2] = k[3]; k[3] = tk;
          ts = s[2]; s[2] = s[3]; s[3] = ts;
        end
        if (rank_gt(k[0], s[0], k[2], s[2])) begin
          tn = n[0]; n[0] = n[2]; n[2] = tn;
          ta = a[0]; a[0] = a[2]; a[2] = ta;
        end
      end
      default: begin
        unk_nxt = 1'b0;
      end
    endcase
    key_nxt = {n[3], n[2], n[1], n[0]};
    for (int j = 0; j < 4; j++) begin
      ao_nxt[j] = a[j];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ORDER) begin
      key_r <= key_nxt;
      unk_r <= unk_nxt;
      for (int j = 0; j < 4; j++) begin
        ao_r[j] <= ao_nxt[j];
      end
    end
  end

  // table search
  assign match     = rd_v_r && (rd_data_r == key_r);
  assign scan_end  = !issue && !rd_v_r;
  assign idx32_hit = 32'(rd_idx_r);
  assign idx32_new = 32'(used_k);
  assign we        = (state_r == S_SEARCH) && !match && scan_end
                     && (used_k < UW'(TYPE_SLOTS));
  assign waddr     = base + AW'(used_k);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_data.kind <= KIND_PLANE) begin
          state_nxt = (in_data.kind == KIND_ATOM) ? S_ORDER : S_RANK;
        end
      end
      S_RANK: begin
        // drain the memory read and the four cells
        if (cnt_r == CW'(used_a) + CW'(5)) begin
          state_nxt = S_ORDER;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_ORDER: begin
        state_nxt = S_SEARCH;
        cnt_nxt   = '0;
      end
      S_SEARCH: begin
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        res_nxt.unknown_rank    = unk_r;
        res_nxt.out_atom_first  = ao_r[0];
        res_nxt.out_atom_second = ao_r[1];
        res_nxt.out_atom_third  = ao_r[2];
        res_nxt.out_atom_fourth = ao_r[3];
        if (match) begin
          state_nxt            = S_DONE;
          res_nxt.type_index   = idx32_hit[7:0];
          res_nxt.newly_added  = 1'b0;
          res_nxt.table_full   = 1'b0;
        end else if (scan_end) begin
          state_nxt = S_DONE;
          if (we) begin
            res_nxt.type_index  = idx32_new[7:0];
            res_nxt.newly_added = 1'b1;
            res_nxt.table_full  = 1'b0;
          end else begin
            res_nxt.type_index  = '0;
            res_nxt.newly_added = 1'b0;
            res_nxt.table_full  = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_KINDS; k++) begin
        used_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_nxt == S_DONE);
      if (we) begin
        used_r[kind_r] <= used_k + UW'(1);
      end
    end
  end

  // a result is only shown from the done state
  `ITD_ASSERT_ALWAYS(a_valid_done, !out_valid || state_r == S_DONE)
  // an insert and a full table never go together
  `ITD_ASSERT_ALWAYS(a_add_full, !out_valid || !(out_data.newly_added && out_data.table_full))
  // no new request while a result waits
  `ITD_ASSERT_ALWAYS(a_stall_busy, !out_valid || in_stall)
  // a write always ends the search
  `ITD_ASSERT_NEXT(a_write_done, we, state_r == S_DONE)

endmodule
`default_nettype wire

### test/interaction_type_dictionary_tb.sv
`default_nettype none
module interaction_type_dictionary_tb;
  import itd_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned RANDOM_ITEMS = 1120;
  localparam int unsigned TAIL_CYCLES = 2 * SLOTS + 40;

  localparam logic [31:0] NM_C = "C";
  localparam logic [31:0] NM_H = "H";
  localparam logic [31:0] NM_O = "O";
  localparam logic [31:0] NM_N = "N";
  localparam logic [31:0] NM_X = "Xx";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  itd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  itd_out_t out_data;

  interaction_type_dictionary #(.TYPE_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the dictionaries: names packed first..fourth, unused zero
  logic [127:0] dict_rows [NUM_KINDS][SLOTS];
  int unsigned dict_used [NUM_KINDS];
  logic [31:0] ord_nm [4];
  logic [15:0] ord_at [4];
  bit rank_missing;

  itd_out_t pending_results [$];
  int unsigned mismatch_count = 0;
  bit stim_done = 1'b0;

  // rank = slot in the atom table, -1 when the name was never added
  function automatic int rank_of(logic [31:0] name);
    for (int i = 0; i < dict_used[0]; i++)
      if (dict_rows[0][i][127:96] === name) return i;
    rank_missing = 1'b1;
    return -1;
  endfunction

  function automatic void swap_pos(int p, int q, bit names_too);
    logic [31:0] tn;
    logic [15:0] ta;
    if (names_too) begin
      tn = ord_nm[p]; ord_nm[p] = ord_nm[q]; ord_nm[q] = tn;
    end
    ta = ord_at[p]; ord_at[p] = ord_at[q]; ord_at[q] = ta;
  endfunction

  function automatic void order_by_rank(int p, int q);
    int rp, rq;
    rp = rank_of(ord_nm[p]);
    rq = rank_of(ord_nm[q]);
    if (rp > rq) swap_pos(p, q, 1'b1);
  endfunction

  // canonical order, lookup and insert; updates the shadow dictionaries
  function automatic itd_out_t lookup_term(itd_in_t t);
    itd_out_t r;
    int members, k;
    int r0, r1, r2, r3;
    logic [127:0] key;
    bit found;
    r = '0;
    k = t.kind;
    members = (t.kind == KIND_ATOM) ? 1 : (t.kind == KIND_BOND) ? 2 :
              (t.kind == KIND_ANGLE) ? 3 : 4;
    ord_nm = '{t.name_first, t.name_second, t.name_third, t.name_fourth};
    ord_at = '{t.atom_first, t.atom_second, t.atom_third, t.atom_fourth};
    for (int j = members; j < 4; j++) begin
      ord_nm[j] = '0;
      ord_at[j] = '0;
    end
    rank_missing = 1'b0;
    case (t.kind)
      KIND_BOND: order_by_rank(0, 1);
      KIND_ANGLE: order_by_rank(0, 2);
      KIND_TORSION: begin
        r1 = rank_of(ord_nm[1]);
        r2 = rank_of(ord_nm[2]);
        if (r1 > r2) begin
          swap_pos(1, 2, 1'b1);
          swap_pos(0, 3, 1'b1);
        end else if (ord_nm[1] === ord_nm[2]) begin
          r0 = rank_of(ord_nm[0]);
          r3 = rank_of(ord_nm[3]);
          if (r0 > r3) begin
            swap_pos(0, 3, 1'b1);
            swap_pos(1, 2, 1'b0);
          end
        end
      end
      KIND_PLANE: begin
        order_by_rank(0, 2);
        order_by_rank(2, 3);
        order_by_rank(0, 2);
      end
      default: ;
    endcase
    key = {ord_nm[0], ord_nm[1], ord_nm[2], ord_nm[3]};
    found = 1'b0;
    for (int i = 0; i < dict_used[k] && !found; i++)
      if (dict_rows[k][i] === key) begin
        found = 1'b1;
        r.type_index = i[7:0];
      end
    if (!found) begin
      if (dict_used[k] < SLOTS) begin
        dict_rows[k][dict_used[k]] = key;
        r.type_index = dict_used[k][7:0];
        r.newly_added = 1'b1;
        dict_used[k]++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    r.unknown_rank = rank_missing;
    r.out_atom_first = ord_at[0];
    r.out_atom_second = ord_at[1];
    r.out_atom_third = ord_at[2];
    r.out_atom_fourth = ord_at[3];
    return r;
  endfunction

  function automatic itd_in_t make_term(logic [2:0] kind, logic [31:0] n0, n1, n2, n3,
                                        logic [15:0] a0, a1, a2, a3);
    itd_in_t t;
    t = '{kind, n0, n1, n2, n3, a0, a1, a2, a3};
    return t;
  endfunction

  function automatic itd_out_t make_result(int idx, bit added, bit unk, bit full,
                                           logic [15:0] a0, a1, a2, a3);
    itd_out_t r;
    r = '{idx[7:0], added, unk, full, a0, a1, a2, a3};
    return r;
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int gap_cycles();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one request, hold it until accepted, then record what it should give
  task automatic send_request(itd_in_t t, bit typed, itd_out_t typed_result);
    itd_out_t predicted;
    int gap;
    gap = gap_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    // kinds above out-of-plane are dropped without a result
    if (t.kind <= KIND_PLANE) begin
      predicted = lookup_term(t);
      pending_results.push_back(typed ? typed_result : predicted);
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // names from a small pool so that terms repeat, now and then a fresh one
  function automatic logic [31:0] pick_name();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return {8'd0, 8'd0, 8'h41 + 8'($urandom_range(0, 3)),
                          8'h41 + 8'($urandom_range(0, 4))};
    return $urandom;
  endfunction

  function automatic itd_in_t random_term(logic [2:0] kind);
    itd_in_t t;
    t = make_term(kind, pick_name(), pick_name(), pick_name(), pick_name(),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    // torsions with equal middle names reach the end-swap rule
    if (kind == KIND_TORSION && $urandom_range(0, 2) == 0) t.name_third = t.name_second;
    return t;
  endfunction

  // result side: stall in stretches of random length, with calm stretches between
  initial begin : stall_driver
    int run;
    bit mode;
    forever begin
      mode = ($urandom_range(0, 3) == 0);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) begin
        mode = 1'b0;
        run = $urandom_range(50, 150);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= mode;
      end
    end
  end

  // checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    itd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  typedef struct {
    itd_in_t term;
    bit typed;
    itd_out_t result;
  } directed_row_t;

  directed_row_t directed [$];

  initial begin : stimulus
    itd_in_t t;
    int sent;
    int kind_sel;
    for (int k = 0; k < NUM_KINDS; k++) dict_used[k] = 0;

    // a few easy rows carry their result, the rest go through the predictor
    directed.push_back('{make_term(KIND_ATOM, NM_C, 0, 0, 0, 16'd7, 0, 0, 0), 1,
                         make_result(0, 1, 0, 0, 16'd7, 0, 0, 0)});
    directed.push_back('{make_term(KIND_ATOM, NM_H, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1,
                         make_result(1, 1, 0, 0, 16'hFFFF, 0, 0, 0)});
    directed.push_back('{make_term(KIND_ATOM, NM_O, 0, 0, 0, 16'd0, 0, 0, 0), 1,
                         make_result(2, 1, 0, 0, 16'd0, 0, 0, 0)});
    directed.push_back('{make_term(KIND_ATOM, NM_C, 0, 0, 0, 16'd9, 0, 0, 0), 1,
                         make_result(0, 0, 0, 0, 16'd9, 0, 0, 0)});
    directed.push_back('{make_term(KIND_ATOM, 32'h0, 0, 0, 0, 16'd1, 0, 0, 0), 1,
                         make_result(3, 1, 0, 0, 16'd1, 0, 0, 0)});
    // unused positions all ones must read back as zero
    directed.push_back('{make_term(KIND_ATOM, '1, '1, '1, '1, '1, '1, '1, '1), 1,
                         make_result(4, 1, 0, 0, 16'hFFFF, 0, 0, 0)});
    directed.push_back('{make_term(KIND_BOND, NM_H, NM_C, '1, '1, 16'd1, 16'd2, '1, '1), 1,
                         make_result(0, 1, 0, 0, 16'd2, 16'd1, 0, 0)});
    directed.push_back('{make_term(KIND_BOND, NM_C, NM_H, 0, 0, 16'd3, 16'd4, 0, 0), 1,
                         make_result(0, 0, 0, 0, 16'd3, 16'd4, 0, 0)});
    directed.push_back('{make_term(KIND_BOND, NM_X, NM_C, 0, 0, 16'd5, 16'd6, 0, 0), 1,
                         make_result(1, 1, 1, 0, 16'd5, 16'd6, 0, 0)});
    directed.push_back('{make_term(KIND_ANGLE, NM_O, NM_C, NM_H, '1, 1, 2, 3, '1), 1,
                         make_result(0, 1, 0, 0, 16'd3, 16'd2, 16'd1, 0)});
    directed.push_back('{make_term(KIND_TORSION, NM_C, NM_O, NM_H, NM_N, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(KIND_TORSION, NM_H, NM_C, NM_C, NM_O, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(KIND_TORSION, NM_O, NM_C, NM_C, NM_H, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(KIND_TORSION, NM_X, NM_N, NM_N, NM_X, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(KIND_PLANE, NM_O, NM_C, NM_H, NM_C, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(KIND_PLANE, NM_X, NM_C, NM_N, NM_O, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(3'd5, NM_C, NM_C, NM_C, NM_C, 1, 2, 3, 4), 0, '0});
    directed.push_back('{make_term(3'd6, '1, '1, '1, '1, '1, '1, '1, '1), 0, '0});
    directed.push_back('{make_term(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{make_term(KIND_PLANE, NM_O, NM_C, NM_H, NM_C, 9, 8, 7, 6), 0, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i].term, directed[i].typed, directed[i].result);
    go_idle();

    // hold off until the dictionary has answered everything sent so far
    while (pending_results.size() != 0) @(posedge clk);

    // random terms over all kinds, growing the pools as they go
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind_sel = $urandom_range(0, 99);
      // the middle stretch fills the atom and bond tables past their capacity
      if (sent >= 300 && sent < 580)
        t = random_term(KIND_ATOM);
      else if (sent >= 580 && sent < 860)
        t = make_term(KIND_BOND, $urandom, $urandom, $urandom, $urandom,
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (kind_sel < 3)
        t = random_term(3'($urandom_range(5, 7)));
      else
        t = random_term(3'($urandom_range(0, 4)));
      if (sent >= 300 && sent < 580) t.name_first = $urandom;
      send_request(t, 1'b0, '0);
      if (t.kind <= KIND_PLANE) sent++;
    end
    go_idle();
    stim_done = 1'b1;
  end

  initial begin : finish_check
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #24000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
